// File: src/wlsl_pkg.sv
// ----------------------------------------------------------------------------
// wlsl_pkg : shared types and constants of the wear-levelled selection log
// Request and response payloads, command and pass-key codes, sequencer states.
// ----------------------------------------------------------------------------
package wlsl_pkg;

    // Request commands
    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Pass keys; bit 0 set marks a reverse (downward) pass
    localparam logic [1:0] KEY_FRONT1   = 2'd0;
    localparam logic [1:0] KEY_REVERSE1 = 2'd1;
    localparam logic [1:0] KEY_FRONT2   = 2'd2;
    localparam logic [1:0] KEY_REVERSE2 = 2'd3;

    // Content of an erased store entry
    localparam logic [7:0] ERASED_ENTRY = 8'hFF;

    typedef struct packed {
        logic       command;
        logic [3:0] item_number;
    } t_wlsl_req;

    typedef struct packed {
        logic       ok;
        logic [3:0] last_item;
        logic [3:0] slot;
    } t_wlsl_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_wlsl_state;

endpackage

// File: src/wear_leveled_selection_log_core.sv
// ----------------------------------------------------------------------------
// wear_leveled_selection_log_core : wear-levelled log of the last selection
// Records and reads back the last selected item in a small entry store.
// ----------------------------------------------------------------------------
// Each request either records a selection (command 0) or reads back the last
// recorded one (command 1), and yields exactly one response. Entries hold a
// pass key in the high nibble and the item in the low nibble; front passes
// fill the store upward, reverse passes downward, so every entry wears
// evenly. To find the end of the current pass the block walks the store one
// entry per cycle through its single read port, comparing each key nibble in
// one shared compare/step unit, and stops at the first entry of another pass
// or after the last entry of the store. The walk is skipped while the pass
// key is still erased, and the block takes no new request during the walk.
// A finished response sits in an output register, so a new request is taken
// while it waits. No clearing pass follows reset: per-entry valid bits make
// unwritten entries read erased.
// ----------------------------------------------------------------------------
module wear_leveled_selection_log_core #(
    parameter int LOG_DEPTH = 16,
    parameter int MAX_ITEM  = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  wlsl_pkg::t_wlsl_req i_req,
    output logic                o_rsp_valid,
    input  logic                i_rsp_ready,
    output wlsl_pkg::t_wlsl_rsp o_rsp
);

    import wlsl_pkg::*;

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(LOG_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(LOG_DEPTH);
    localparam logic [CW-1:0] LAST_CNT  = CW'(LOG_DEPTH - 1);

    // Map a step along the pass to a store slot: upward or downward
    function automatic logic [AW-1:0] f_pos(input logic [AW-1:0] step,
                                            input logic rev);
        return rev ? (LAST_SLOT - step) : step;
    endfunction

    // Control and sequencer state
    t_wlsl_state r_state, n_state;
    logic        r_cmd;
    logic [3:0]  r_item;
    logic [1:0]  r_key;
    logic        r_key_erased;
    logic [CW-1:0] r_cnt;      // reads issued in this walk
    logic        r_pend;       // read data due this cycle
    logic [CW-1:0] r_hits;     // entries matching the key so far
    logic [7:0]  r_last;       // last matching entry
    logic        r_out_valid;
    t_wlsl_rsp   r_out;

    // Store interface
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // Sequencer outputs
    logic      req_take;
    logic      scan_stop;
    logic      finish_go;
    logic      key_match;
    logic      pass_full;
    logic [1:0] rec_key;
    logic [AW-1:0] rec_idx;
    logic [AW-1:0] rd_idx;
    logic      rd_ok;
    t_wlsl_rsp rsp_next;

    wlsl_store #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Shared compare unit: key nibble of the entry just read
    assign key_match = (rd_data[7:4] == {2'b00, r_key});
    // Stop on the first foreign entry, or once the last entry has matched
    assign scan_stop = r_pend && (!key_match || (r_hits == LAST_CNT));
    assign pass_full = (r_hits == FULL_CNT);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = r_key_erased ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_stop) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs and finishing datapath
    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        req_take    = o_req_ready && i_req_valid;
        finish_go   = (r_state == S_FINISH) && (!r_out_valid || i_rsp_ready);

        // issue one read per cycle along the pass
        rd_en   = (r_state == S_SCAN) && (r_cnt != FULL_CNT) && !scan_stop;
        rd_addr = f_pos(r_cnt[AW-1:0], r_key[0]);

        // record: step past the end; a full pass advances the key and
        // restarts at the same end of the store
        if (r_key_erased) begin
            rec_key = KEY_FRONT1;
            rec_idx = '0;
        end else if (pass_full) begin
            rec_key = r_key + 2'd1;
            rec_idx = f_pos(LAST_SLOT, r_key[0]);
        end else begin
            rec_key = r_key;
            rec_idx = f_pos(r_hits[AW-1:0], r_key[0]);
        end

        // read: the last matching entry, if any, with a legal item
        rd_idx = f_pos(AW'(r_hits - CW'(1)), r_key[0]);
        rd_ok  = !r_key_erased && (r_hits != '0) && (r_last[3:0] <= 4'(MAX_ITEM));

        if (r_cmd == CMD_RECORD) begin
            rsp_next.ok        = 1'b1;
            rsp_next.last_item = r_item;
            rsp_next.slot      = 4'(rec_idx);
        end else begin
            rsp_next.ok        = rd_ok;
            rsp_next.last_item = rd_ok ? r_last[3:0] : 4'd0;
            rsp_next.slot      = rd_ok ? 4'(rd_idx) : 4'd0;
        end

        wr_en   = finish_go && (r_cmd == CMD_RECORD);
        wr_addr = rec_idx;
        wr_data = {2'b00, rec_key, r_item};
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_key_erased <= 1'b1;
            r_key        <= KEY_FRONT1;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= rd_en;
            if (wr_en) begin
                r_key_erased <= 1'b0;
                r_key        <= rec_key;
            end
            if (finish_go) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk counters and payload
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_cmd  <= i_req.command;
            r_item <= i_req.item_number;
            r_cnt  <= '0;
            r_hits <= '0;
        end else begin
            if (rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end
            // advance past each matching entry and hold it for a read
            if (r_pend && key_match) begin
                r_hits <= r_hits + CW'(1);
                r_last <= rd_data;
            end
        end
        if (finish_go) begin
            r_out <= rsp_next;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

// File: src/wlsl_ram.sv
// ----------------------------------------------------------------------------
// wlsl_ram : generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wlsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/wlsl_store.sv
// ----------------------------------------------------------------------------
// wlsl_store : log entry store
// RAM with one valid bit per entry; an entry never written reads as erased.
// ----------------------------------------------------------------------------
module wlsl_store #(
    parameter int LOG_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [$clog2(LOG_DEPTH)-1:0] i_wr_addr,
    input  logic [7:0]                   i_wr_data,
    input  logic                         i_rd_en,
    input  logic [$clog2(LOG_DEPTH)-1:0] i_rd_addr,
    output logic [7:0]                   o_rd_data
);

    import wlsl_pkg::*;

    logic [LOG_DEPTH-1:0] r_valid;
    logic                 r_rd_valid;
    logic [7:0]           ram_q;

    wlsl_ram #(
        .WIDTH (8),
        .DEPTH (LOG_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    // mark entries as written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // track validity alongside the registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_valid ? ram_q : ERASED_ENTRY;

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top : self-checking bench for the wear-levelled selection log
// Drives record and read requests through the valid/ready request channel,
// predicts every response from a private image of the pass key and the entry
// store, and compares each accepted response field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wlsl_pkg::*;

    localparam int LOG_DEPTH       = 16;
    localparam int MAX_ITEM        = 4;
    // Allow generous headroom over the longest walk of a request.
    localparam int TAIL_CYCLES     = 4 * (LOG_DEPTH + 3);
    localparam int HOLD_OFF_CYCLES = 300;
    // No handshake for this long means the block is stuck.
    localparam int STALL_LIMIT     = 2000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      req_valid   = 1'b0;
    logic      req_ready;
    t_wlsl_req req_bus     = '0;
    logic      rsp_valid;
    logic      rsp_ready   = 1'b0;
    t_wlsl_rsp rsp_bus;

    // Predictor state: a private copy of the pass key and the entry store.
    logic [7:0] key_image;
    logic [7:0] log_image [LOG_DEPTH];

    // Responses still owed by the block, oldest first.
    t_wlsl_rsp  pending_rsp [$];

    int         error_count   = 0;
    int         quiet_cycles  = 0;
    int         hold_off_left = 0;
    bit         no_idling     = 1'b0;

    wear_leveled_selection_log_core #(
        .LOG_DEPTH (LOG_DEPTH),
        .MAX_ITEM  (MAX_ITEM)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req_bus),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp_bus)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic bit key_is_front(logic [7:0] key);
        return key == KEY_FRONT1 || key == KEY_FRONT2;
    endfunction

    function automatic bit key_is_reverse(logic [7:0] key);
        return key == KEY_REVERSE1 || key == KEY_REVERSE2;
    endfunction

    // Step the pass key round front1, reverse1, front2, reverse2.
    function automatic logic [7:0] key_after(logic [7:0] key);
        case (key)
            KEY_FRONT1:   return KEY_REVERSE1;
            KEY_REVERSE1: return KEY_FRONT2;
            KEY_FRONT2:   return KEY_REVERSE2;
            default:      return KEY_FRONT1;
        endcase
    endfunction

    // Last slot of the current pass; -1 or LOG_DEPTH when there is none.
    function automatic int pass_last_slot(logic [7:0] key);
        if (key_is_front(key)) begin
            for (int i = 0; i < LOG_DEPTH; i++)
                if (log_image[i][7:4] != key) return i - 1;
            return LOG_DEPTH - 1;
        end
        if (key_is_reverse(key)) begin
            for (int i = LOG_DEPTH - 1; i >= 0; i--)
                if (log_image[i][7:4] != key) return i + 1;
            return 0;
        end
        return -1;
    endfunction

    // Work out the response to one request and advance the store image.
    function automatic t_wlsl_rsp log_predict(t_wlsl_req req);
        t_wlsl_rsp  rsp;
        logic [7:0] key;
        logic [7:0] entry;
        int         pos;
        key = key_image;
        pos = pass_last_slot(key);
        rsp = '0;
        if (req.command == CMD_RECORD) begin
            if (key_is_front(key)) begin
                pos++;
                if (pos < 0 || pos >= LOG_DEPTH) begin
                    key = key_after(key);
                    pos = LOG_DEPTH - 1;
                end
            end else if (key_is_reverse(key)) begin
                pos--;
                if (pos < 0 || pos >= LOG_DEPTH) begin
                    key = key_after(key);
                    pos = 0;
                end
            end else begin
                key = KEY_FRONT1;
                pos = 0;
            end
            key_image      = key;
            log_image[pos] = {key[3:0], req.item_number};
            rsp.ok         = 1'b1;
            rsp.last_item  = req.item_number;
            rsp.slot       = 4'(pos);
        end else if (pos >= 0 && pos < LOG_DEPTH) begin
            entry = log_image[pos];
            if (entry[3:0] <= MAX_ITEM && (key_is_front(key) || key_is_reverse(key))
                    && entry[7:4] == key) begin
                rsp.ok        = 1'b1;
                rsp.last_item = entry[3:0];
                rsp.slot      = 4'(pos);
            end
        end
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: sample both channels at the rising edge. Retire a response
    // before queueing the new prediction, so a stray response can never be
    // matched against a request taken on the same edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : rsp_check
        t_wlsl_rsp want;
        if (!i_rst_n) begin
            key_image = ERASED_ENTRY;
            for (int i = 0; i < LOG_DEPTH; i++) log_image[i] = ERASED_ENTRY;
        end else begin
            if (rsp_valid && rsp_ready) begin
                if (pending_rsp.size() == 0) begin
                    $display("%0t: unexpected response, expected none, actual ok=%0b item=%0d slot=%0d",
                             $time, rsp_bus.ok, rsp_bus.last_item, rsp_bus.slot);
                    error_count++;
                end else begin
                    want = pending_rsp.pop_front();
                    if (rsp_bus.ok !== want.ok || rsp_bus.last_item !== want.last_item
                            || rsp_bus.slot !== want.slot) begin
                        $display("%0t: response mismatch, expected ok=%0b item=%0d slot=%0d, actual ok=%0b item=%0d slot=%0d",
                                 $time, want.ok, want.last_item, want.slot,
                                 rsp_bus.ok, rsp_bus.last_item, rsp_bus.slot);
                        error_count++;
                    end
                end
            end
            if (req_valid && req_ready)
                pending_rsp.push_back(log_predict(req_bus));
        end
    end

    // Watchdog: count cycles without any handshake on either channel.
    always @(posedge i_clk) begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                     $time, quiet_cycles, pending_rsp.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Response side: drive ready at the falling edge. Honour a long hold-off
    // first, then either hold ready high (quiet tail) or alternate random
    // bursts of ready and stall.
    // ------------------------------------------------------------------------
    initial begin : rsp_side
        int   burst_left;
        logic burst_level;
        burst_left  = 0;
        burst_level = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                rsp_ready <= 1'b0;
                hold_off_left--;
            end else if (no_idling) begin
                rsp_ready <= 1'b1;
            end else begin
                if (burst_left == 0) begin
                    burst_level = ($urandom_range(0, 2) != 0);
                    burst_left  = $urandom_range(1, 16);
                end
                rsp_ready <= burst_level;
                burst_left--;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side helpers; all of them start and end on a falling edge.
    // ------------------------------------------------------------------------

    // Offer one request and hold it until the block takes it. Leave valid
    // high: the caller either offers the next request or drops valid.
    task automatic send_request(logic cmd, logic [3:0] item);
        req_valid             <= 1'b1;
        req_bus.command       <= cmd;
        req_bus.item_number   <= item;
        do @(posedge i_clk); while (!req_ready);
        @(negedge i_clk);
    endtask

    // Drop valid and idle the request side for a number of cycles.
    task automatic sender_gap(int cycles);
        req_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Maybe insert a random idle burst before the next request.
    task automatic maybe_gap();
        if (!no_idling && $urandom_range(0, 3) == 0)
            sender_gap($urandom_range(1, 16));
    endtask

    // Mostly records of legal items, some out-of-range items, many reads.
    task automatic send_random_request();
        logic [3:0] item;
        item = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 99) < 60) begin
            if ($urandom_range(0, 99) < 85)
                item = 4'($urandom_range(0, MAX_ITEM));
            send_request(CMD_RECORD, item);
        end else begin
            send_request(CMD_READ, item);
        end
    endtask

    // Drop valid and wait until every outstanding response has arrived.
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_rsp.size() != 0) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Read with the key still erased: no pass exists, so the read fails.
    task automatic test_erased_reads();
        send_request(CMD_READ, 4'd0);
        maybe_gap();
        send_request(CMD_READ, 4'hF);
        wait_for_drain();
    endtask

    // First record claims front1 at slot 0; exercise item extremes and
    // items above the limit, which are stored but read back as failures.
    task automatic test_record_extremes();
        send_request(CMD_RECORD, 4'd0);
        send_request(CMD_READ, 4'd0);
        send_request(CMD_RECORD, 4'(MAX_ITEM));
        send_request(CMD_READ, 4'hF);
        send_request(CMD_RECORD, 4'(MAX_ITEM + 1));
        send_request(CMD_READ, 4'd0);
        send_request(CMD_RECORD, 4'hF);
        send_request(CMD_READ, 4'h5);
        send_request(CMD_RECORD, 4'hA);
        send_request(CMD_RECORD, 4'h5);
        send_request(CMD_RECORD, 4'd1);
        send_request(CMD_READ, 4'hA);
        wait_for_drain();
    endtask

    // Random traffic with idle bursts on both sides; occasionally pause
    // the request side until the block has answered everything.
    task automatic test_random_traffic(int count);
        for (int n = 0; n < count; n++) begin
            maybe_gap();
            send_random_request();
            if ($urandom_range(0, 99) == 0) wait_for_drain();
        end
        wait_for_drain();
    endtask

    // Hold off the response side for a long stretch while requests keep
    // coming back to back, so the block fills up and stalls its input.
    task automatic test_response_stall(int count);
        hold_off_left = HOLD_OFF_CYCLES;
        for (int n = 0; n < count; n++) send_random_request();
        wait_for_drain();
    endtask

    // Pause the sender until everything is answered, then carry on.
    task automatic test_sender_pause(int count);
        for (int n = 0; n < count; n++) begin
            send_random_request();
            wait_for_drain();
        end
    endtask

    // Close with full throughput on both sides.
    task automatic test_tail_without_gaps(int count);
        no_idling = 1'b1;
        for (int n = 0; n < count; n++) send_random_request();
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        // Hold reset, then release it on a falling edge.
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_erased_reads();
        test_record_extremes();
        test_random_traffic(400);
        test_response_stall(12);
        test_sender_pause(6);
        test_random_traffic(410);
        test_tail_without_gaps(110);

        // Let any late or stray response show before judging the run.
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
